FILE: rtl/tkpq_pkg.sv
package tkpq_pkg;

    localparam int CLASS_W    = 2;
    localparam int CLIENT_W   = 16;
    localparam int DURATION_W = 16;
    localparam int STATUS_W   = 2;
    localparam int TDATA_W    = 40;

    typedef struct packed {
        logic [CLASS_W-1:0]    rec_class;
        logic [CLIENT_W-1:0]   client;
        logic [DURATION_W-1:0] duration;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    // operation codes carried in s_tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // result status codes carried in m_tuser
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

endpackage

FILE: rtl/two_key_priority_queue_core.sv
// Bounded priority queue of call records (class, client, duration) kept sorted by class,
// then by duration, smallest at the head; equal keys leave in arrival order. Records live
// in a single-port-write, single-port-read memory used as a ring, so a remove only reads
// the head entry and advances the ring start. A remove reads the head from idle, takes the
// record in ST_POP and goes on through ST_DONE to the output register. An insert walks the
// stored records from the tail toward the head through one comparator, moving each larger
// record up one slot: ST_READ reads it and ST_CMP compares it and writes it one slot up. When
// every stored record is larger (at most CAPACITY-1 of them), the new one lands at the head in
// ST_PLACE; else ST_CMP writes it behind the first record that is not larger. An insert into
// an empty or full queue, or a remove on an empty queue, goes straight to ST_DONE. One
// transaction is handled at a time; s_tready is high only while the sequencer is idle. The
// result is held in an output register until taken, and no clearing pass is needed after
// reset.
module two_key_priority_queue_core
    import tkpq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // [1:0] record_class, [17:2] client_number, [33:18] call_duration
    input  logic [TDATA_W-1:0] s_tdata,
    // [0] operation
    input  logic [0:0]         s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    // [1:0] head_class, [17:2] head_client, [33:18] head_duration, [34] now_empty
    output logic [TDATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [1:0]         m_tuser
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = $clog2(2 * CAPACITY);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_CMP   = 3'd2;
    localparam logic [2:0] ST_PLACE = 3'd3;
    localparam logic [2:0] ST_POP   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    rec_t                new_reg, new_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    rec_t                res_rec_reg, res_rec_next;
    logic                res_empty_reg, res_empty_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    rec_t                out_rec_reg, out_rec_next;
    logic                out_empty_reg, out_empty_next;

    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    rec_t                wr_data;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    rec_t                rd_data;

    rec_t                in_rec;
    logic                stored_larger;
    logic                out_load;

    // logical position in the sorted list to ring address
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [IDX_W-1:0] lidx);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(lidx);
        if (sum >= SUM_W'(CAPACITY)) begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    tkpq_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_rec.rec_class = s_tdata[1:0];
    assign in_rec.client    = s_tdata[17:2];
    assign in_rec.duration  = s_tdata[33:18];

    // shared key comparator: stored record must move behind the new one
    assign stored_larger = (rd_data.rec_class > new_reg.rec_class) ||
                           ((rd_data.rec_class == new_reg.rec_class) &&
                            (rd_data.duration > new_reg.duration));

    assign s_tready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        idx_next        = idx_reg;
        new_next        = new_reg;
        res_status_next = res_status_reg;
        res_rec_next    = res_rec_reg;
        res_empty_next  = res_empty_reg;
        wr_en           = 1'b0;
        wr_addr         = phys(head_reg, idx_reg + IDX_W'(1));
        wr_data         = new_reg;
        rd_en           = 1'b0;
        rd_addr         = phys(head_reg, idx_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    new_next     = in_rec;
                    res_rec_next = '0;
                    if (s_tuser[0] == OP_REMOVE) begin
                        if (count_reg == '0) begin
                            res_status_next = STATUS_EMPTY;
                            res_empty_next  = 1'b1;
                            state_next      = ST_DONE;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            state_next = ST_POP;
                        end
                    end else if (count_reg == CNT_W'(CAPACITY)) begin
                        res_status_next = STATUS_FULL;
                        res_empty_next  = 1'b0;
                        state_next      = ST_DONE;
                    end else if (count_reg == '0) begin
                        wr_en           = 1'b1;
                        wr_addr         = head_reg;
                        wr_data         = in_rec;
                        count_next      = count_reg + CNT_W'(1);
                        res_status_next = STATUS_DONE;
                        res_empty_next  = 1'b0;
                        state_next      = ST_DONE;
                    end else begin
                        // start at the tail; count is below capacity here
                        idx_next   = count_reg[IDX_W-1:0] - IDX_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                rd_en      = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (stored_larger) begin
                    wr_en   = 1'b1;
                    wr_data = rd_data;
                    if (idx_reg == '0) begin
                        state_next = ST_PLACE;
                    end else begin
                        idx_next   = idx_reg - IDX_W'(1);
                        state_next = ST_READ;
                    end
                end else begin
                    wr_en           = 1'b1;
                    count_next      = count_reg + CNT_W'(1);
                    res_status_next = STATUS_DONE;
                    res_empty_next  = 1'b0;
                    state_next      = ST_DONE;
                end
            end
            ST_PLACE: begin
                wr_en           = 1'b1;
                wr_addr         = head_reg;
                count_next      = count_reg + CNT_W'(1);
                res_status_next = STATUS_DONE;
                res_empty_next  = 1'b0;
                state_next      = ST_DONE;
            end
            ST_POP: begin
                head_next       = phys(head_reg, IDX_W'(1));
                count_next      = count_reg - CNT_W'(1);
                res_rec_next    = rd_data;
                res_status_next = STATUS_DONE;
                res_empty_next  = (count_reg == CNT_W'(1));
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_rec_next    = out_rec_reg;
        out_empty_next  = out_empty_reg;
        if (out_load) begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_rec_next    = res_rec_reg;
            out_empty_next  = res_empty_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        new_reg        <= new_next;
        res_status_reg <= res_status_next;
        res_rec_reg    <= res_rec_next;
        res_empty_reg  <= res_empty_next;
        out_status_reg <= out_status_next;
        out_rec_reg    <= out_rec_next;
        out_empty_reg  <= out_empty_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {5'b0, out_empty_reg, out_rec_reg.duration,
                       out_rec_reg.client, out_rec_reg.rec_class};

endmodule

FILE: rtl/tkpq_ram.sv
module tkpq_ram
    import tkpq_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  rec_t              wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output rec_t              rd_data
);

    rec_t mem [DEPTH];
    rec_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
